/* hw/rtl/rational_arithmetic_unit_macros.svh */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_macros
// Assertion macros used by the rational arithmetic unit controller.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// Implication checked on every edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int CMD_W = 4;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_GT  = 4'd4,
        CMD_GE  = 4'd5,
        CMD_LT  = 4'd6,
        CMD_LE  = 4'd7,
        CMD_EQ  = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture operands, form cross products
        logic prep;      // form the unreduced numerator, denominator and magnitudes
        logic gcd_step;  // one step of the gcd loop
        logic div_start; // start an exact division
        logic div_step;  // one quotient bit
        logic div_num;   // store quotient as numerator
        logic div_den;   // marks the denominator quotient; the datapath stores it on finish
        logic finish;    // form output fields
    } ctl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic special; // result needs no reduction
        logic gcd_done;
        logic div_done;
    } sts_t;

endpackage

/* hw/rtl/rational_arithmetic_unit.sv */
// Arithmetic commands pass through load, prep, the gcd loop and two exact divisions
// before the result is held; compares go from prep straight to the result.
// Zero results and bad operands also take that short path; output stalls hold the result.
// Requests: one at a time, taken again in the cycle after the result leaves;
// the bit-serial gcd sets how long each request takes.
// Reset: rst_n clears the controller to idle; datapath holds no reset.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add, subtract, multiply, divide with gcd reduction and compares.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
#(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rau_pkg::CMD_W-1:0]       cmd,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic [OPERAND_WIDTH-2:0]        a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic [OPERAND_WIDTH-2:0]        b_den,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [2*OPERAND_WIDTH:0] res_num,
    output logic [2*OPERAND_WIDTH-2:0]      res_den,
    output logic                            cmp_true,
    output logic                            bad_operand
);

    rau_pkg::ctl_t ctl;
    rau_pkg::sts_t sts;

    rau_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    rau_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp
    (
        .clk         (clk),
        .ctl         (ctl),
        .sts         (sts),
        .cmd         (cmd),
        .a_num       (a_num),
        .a_den       (a_den),
        .b_num       (b_num),
        .b_den       (b_den),
        .res_num     (res_num),
        .res_den     (res_den),
        .cmp_true    (cmp_true),
        .bad_operand (bad_operand)
    );

endmodule

/* hw/rtl/rau_ctrl.sv */
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: load, reduce by gcd, two exact divisions (skipped for special cases), hold the result.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"
module rau_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  rau_pkg::sts_t   sts,
    output rau_pkg::ctl_t   ctl
);

    rau_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = rau_pkg::ST_PREP;
                end
            end
            rau_pkg::ST_PREP:
            begin
                ctl.prep   = 1'b1;
                state_next = rau_pkg::ST_GCD;
            end
            rau_pkg::ST_GCD:
            begin
                if (sts.special)
                begin
                    ctl.finish = 1'b1;
                    state_next = rau_pkg::ST_DONE;
                end
                else if (sts.gcd_done)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = rau_pkg::ST_DIVN;
                end
                else
                begin
                    ctl.gcd_step = 1'b1;
                end
            end
            rau_pkg::ST_DIVN:
            begin
                if (sts.div_done)
                begin
                    ctl.div_num   = 1'b1;
                    ctl.div_start = 1'b1;
                    state_next    = rau_pkg::ST_DIVD;
                end
                else
                begin
                    ctl.div_step = 1'b1;
                end
            end
            rau_pkg::ST_DIVD:
            begin
                if (sts.div_done)
                begin
                    ctl.div_den = 1'b1;
                    ctl.finish  = 1'b1;
                    state_next  = rau_pkg::ST_DONE;
                end
                else
                begin
                    ctl.div_step = 1'b1;
                end
            end
            rau_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rau_pkg::ST_IDLE;
            end
        endcase
    end

    `RAU_ASSERT_IMP(a_excl_hs, clk, rst_n, 1'b1, !(in_ready && out_valid))
    `RAU_ASSERT_NEXT(a_load_prep, clk, rst_n, ctl.load, state_reg == rau_pkg::ST_PREP)
    `RAU_ASSERT_NEXT(a_finish_done, clk, rst_n, ctl.finish, out_valid)
    `RAU_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0({ctl.gcd_step, ctl.div_step, ctl.load}))

endmodule

/* hw/rtl/rau_dp.sv */
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: cross products, Euclid gcd by shift-subtract remainders,
// restoring division by the gcd, output fields.
// ----------------------------------------------------------------------------
module rau_dp
#(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
)
(
    input  logic                         clk,
    input  rau_pkg::ctl_t                ctl,
    output rau_pkg::sts_t                sts,
    input  logic [rau_pkg::CMD_W-1:0]    cmd,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic [OPERAND_WIDTH-2:0]     a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic [OPERAND_WIDTH-2:0]     b_den,
    output logic signed [2*OPERAND_WIDTH:0] res_num,
    output logic [2*OPERAND_WIDTH-2:0]   res_den,
    output logic                         cmp_true,
    output logic                         bad_operand
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;         // product width
    localparam int MW = 2 * W + 1;     // magnitude width
    localparam int CW = $clog2(MW + 1);

    logic [rau_pkg::CMD_W-1:0] cmd_reg;
    logic signed [PW-1:0] left_reg, right_reg, nn_reg, dd_reg;
    logic                 bad_reg, zero_reg, neg_reg;
    logic [MW-1:0]        x_reg, y_reg, nm_reg, dm_reg;
    logic [MW-1:0]        rem_reg, quo_reg, dvd_reg, qn_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 in_rem_reg;  // x reduction mod y in progress
    logic [MW-1:0]        r_reg;
    logic [CW-1:0]        rcnt_reg;
    logic signed [PW:0]   res_num_reg;
    logic [PW-2:0]        res_den_reg;
    logic                 cmp_reg, bado_reg;

    logic                 is_cmp, is_bad, special;
    logic [MW:0]          trial;
    logic [MW:0]          rtrial;

    assign is_cmp = (cmd_reg >= rau_pkg::CMD_GT) && (cmd_reg <= rau_pkg::CMD_EQ);
    assign is_bad = bad_reg || (cmd_reg == rau_pkg::CMD_DIV && right_reg == '0 && dd_reg == '0);
    assign special = bad_reg || is_cmp || zero_reg;

    // Remainder step for gcd: bit-serial x mod y.
    assign rtrial = {r_reg, x_reg[MW-1]} - {1'b0, y_reg};
    // Division step: dividend bits shifted into remainder.
    assign trial  = {rem_reg, dvd_reg[MW-1]} - {1'b0, x_reg};

    assign sts.special  = special;
    assign sts.gcd_done = (y_reg == '0) && !in_rem_reg;
    assign sts.div_done = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            left_reg  <= PW'(a_num * $signed({1'b0, b_den}));
            right_reg <= PW'($signed({1'b0, a_den}) * b_num);
            nn_reg    <= PW'(a_num * b_num);
            dd_reg    <= PW'($signed({1'b0, a_den}) * $signed({1'b0, b_den}));
            bad_reg   <= (cmd > rau_pkg::CMD_EQ) || (a_den == '0) || (b_den == '0)
                         || (cmd == rau_pkg::CMD_DIV && b_num == '0);
            in_rem_reg <= 1'b0;
        end
        if (ctl.prep)
        begin
            logic signed [PW:0] n;
            logic signed [PW:0] d;
            n = '0;
            d = '0;
            case (cmd_reg)
                rau_pkg::CMD_ADD:
                begin
                    n = (PW+1)'(left_reg) + (PW+1)'(right_reg);
                    d = (PW+1)'(dd_reg);
                end
                rau_pkg::CMD_SUB:
                begin
                    n = (PW+1)'(left_reg) - (PW+1)'(right_reg);
                    d = (PW+1)'(dd_reg);
                end
                rau_pkg::CMD_MUL:
                begin
                    n = (PW+1)'(nn_reg);
                    d = (PW+1)'(dd_reg);
                end
                default:
                begin
                    n = (PW+1)'(left_reg);
                    d = (PW+1)'(right_reg);
                end
            endcase
            neg_reg  <= n[PW] ^ d[PW];
            zero_reg <= (n == '0) || (d == '0);
            x_reg    <= n[PW] ? MW'(-n) : MW'(n);
            y_reg    <= d[PW] ? MW'(-d) : MW'(d);
            nm_reg   <= n[PW] ? MW'(-n) : MW'(n);
            dm_reg   <= d[PW] ? MW'(-d) : MW'(d);
        end
        if (ctl.gcd_step)
        begin
            if (!in_rem_reg)
            begin
                in_rem_reg <= 1'b1;
                r_reg      <= '0;
                rcnt_reg   <= CW'(MW);
            end
            else if (rcnt_reg != '0)
            begin
                rcnt_reg <= rcnt_reg - 1'b1;
                x_reg    <= {x_reg[MW-2:0], 1'b0};
                if (!rtrial[MW])
                begin
                    r_reg <= rtrial[MW-1:0];
                end
                else
                begin
                    r_reg <= {r_reg[MW-2:0], x_reg[MW-1]};
                end
            end
            else
            begin
                // x <- y, y <- x mod y
                x_reg      <= y_reg;
                y_reg      <= r_reg;
                in_rem_reg <= 1'b0;
            end
        end
        if (ctl.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= CW'(MW);
            dvd_reg <= ctl.div_num ? dm_reg : nm_reg;
        end
        if (ctl.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            dvd_reg <= {dvd_reg[MW-2:0], 1'b0};
            if (!trial[MW])
            begin
                rem_reg <= trial[MW-1:0];
                quo_reg <= {quo_reg[MW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[MW-2:0], dvd_reg[MW-1]};
                quo_reg <= {quo_reg[MW-2:0], 1'b0};
            end
        end
        if (ctl.div_num)
        begin
            qn_reg <= quo_reg;
        end
        if (ctl.finish)
        begin
            bado_reg <= is_bad;
            cmp_reg  <= 1'b0;
            res_num_reg <= '0;
            res_den_reg <= (PW-1)'(1);
            if (!bad_reg && is_cmp)
            begin
                case (cmd_reg)
                    rau_pkg::CMD_GT: cmp_reg <= left_reg >  right_reg;
                    rau_pkg::CMD_GE: cmp_reg <= left_reg >= right_reg;
                    rau_pkg::CMD_LT: cmp_reg <= left_reg <  right_reg;
                    rau_pkg::CMD_LE: cmp_reg <= left_reg <= right_reg;
                    default:         cmp_reg <= left_reg == right_reg;
                endcase
            end
            else if (!special)
            begin
                res_num_reg <= neg_reg ? -$signed(qn_reg) : $signed(qn_reg);
                res_den_reg <= (PW-1)'(quo_reg);
            end
        end
    end

    assign res_num     = res_num_reg;
    assign res_den     = res_den_reg;
    assign cmp_true    = cmp_reg;
    assign bad_operand = bado_reg;

endmodule
